// ===== sv/oli_pkg.sv =====
`default_nettype none

package oli_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 6;
    localparam int CMP_W    = POS_W + 1;

    localparam logic [FUNC_W-1:0] FUNC_INS_FRONT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INS_BACK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE    = 2'd2;

    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [CNT_W-1:0]        t_count;
    typedef logic [IDX_W-1:0]        t_index;
    typedef logic [POS_W-1:0]        t_pos;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INS_FRONT,
        CELL_INS_BACK,
        CELL_DELETE,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_count   count;
        t_pos     pos;
        t_value   value;
        t_value   first;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== sv/oli_req_if.sv =====
`default_nettype none

interface oli_req_if;
    logic                valid;
    logic                ready;
    logic [1:0]          func;
    logic signed [31:0]  value;
    logic [5:0]          position;

    modport source (output valid, output func, output value, output position, input ready);
    modport sink   (input valid, input func, input value, input position, output ready);
endinterface

`default_nettype wire

// ===== sv/oli_rsp_if.sv =====
`default_nettype none

interface oli_rsp_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  item_value;
    logic                last_of_run;
    logic                list_empty;
    logic                dropped_full;

    modport source (output valid, output item_value, output last_of_run, output list_empty,
                    output dropped_full, input ready);
    modport sink   (input valid, input item_value, input last_of_run, input list_empty,
                    input dropped_full, output ready);
endinterface

`default_nettype wire

// ===== sv/oli_cell.sv =====
`default_nettype none

module oli_cell (
    input  wire                      i_clk,
    input  wire oli_pkg::t_index     i_index,
    input  wire oli_pkg::t_cell_ctrl i_ctrl,
    input  wire oli_pkg::t_value     i_prev,
    input  wire oli_pkg::t_value     i_next,
    output oli_pkg::t_value          o_data
);
    import oli_pkg::*;

    t_value           r_data;
    t_value           n_data;
    logic [CMP_W-1:0] idx_c;
    logic [CMP_W-1:0] cnt_c;
    logic [CMP_W-1:0] pos_c;

    assign idx_c = CMP_W'(i_index);
    assign cnt_c = CMP_W'(i_ctrl.count);
    assign pos_c = CMP_W'(i_ctrl.pos);

    always_comb begin
        n_data = r_data;
        unique case (i_ctrl.op)
            CELL_HOLD: n_data = r_data;
            CELL_INS_FRONT: begin
                n_data = (idx_c == '0) ? i_ctrl.value : i_prev;
            end
            CELL_INS_BACK: begin
                if (idx_c == cnt_c) begin
                    n_data = i_ctrl.value;
                end
            end
            CELL_DELETE: begin
                if (idx_c >= pos_c) begin
                    n_data = i_next;
                end
            end
            CELL_ROTATE: begin
                if (idx_c + CMP_W'(1) == cnt_c) begin
                    n_data = i_ctrl.first;
                end else if (idx_c + CMP_W'(1) < cnt_c) begin
                    n_data = i_next;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== sv/ordered_list_insert_delete_top.sv =====
// Channel   Direction  Interface    Payload
// i_req     in         oli_req_if   func, value, position
// o_rsp     out        oli_rsp_if   item_value, last_of_run, list_empty, dropped_full
//
// A request is applied to the cell row when it is accepted; then one word is emitted per
// listed entry (one word for an empty list) as the entries rotate through the cell row.
// Each emitted word rotates the row by one place, and after count words the order is restored.
// A stalled output holds the row still; a new request is taken once the last word is loaded.
// Reset clears the count and control state; entry contents are not reset.
`default_nettype none

module ordered_list_insert_delete_top (
    input  wire     i_clk,
    input  wire     i_rst_n,
    oli_req_if.sink   i_req,
    oli_rsp_if.source o_rsp
);
    import oli_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    t_state     r_state;
    t_count     r_count;
    t_count     n_count;
    t_count     r_emit_idx;
    logic       r_dropped;
    logic       n_dropped;
    logic       r_out_valid;
    t_value     r_item;
    logic       r_last;
    logic       r_empty;
    logic       r_out_drop;
    logic       accept;
    logic       load;
    logic       last_word;
    t_cell_ctrl ctrl;
    t_value     cell_data [CAPACITY];

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign load        = (r_state == ST_EMIT) && (!r_out_valid || o_rsp.ready);
    assign last_word   = (r_count == '0) || (r_emit_idx + t_count'(1) == r_count);

    always_comb begin
        ctrl.op    = CELL_HOLD;
        ctrl.count = r_count;
        ctrl.pos   = i_req.position;
        ctrl.value = i_req.value;
        ctrl.first = cell_data[0];
        n_count    = r_count;
        n_dropped  = r_dropped;
        if (accept) begin
            n_dropped = 1'b0;
            priority if (i_req.func == FUNC_INS_FRONT || i_req.func == FUNC_INS_BACK) begin
                if (r_count == t_count'(CAPACITY)) begin
                    n_dropped = 1'b1;
                end else begin
                    ctrl.op = (i_req.func == FUNC_INS_FRONT) ? CELL_INS_FRONT : CELL_INS_BACK;
                    n_count = r_count + t_count'(1);
                end
            end else if (i_req.func == FUNC_DELETE) begin
                if (CMP_W'(i_req.position) < CMP_W'(r_count)) begin
                    ctrl.op = CELL_DELETE;
                    n_count = r_count - t_count'(1);
                end
            end else begin
                ctrl.op = CELL_HOLD;
            end
        end else if (load && r_count != '0) begin
            ctrl.op = CELL_ROTATE;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_value prev_d;
        t_value next_d;
        if (g == 0) begin : g_first
            assign prev_d = '0;
        end else begin : g_mid_p
            assign prev_d = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign next_d = '0;
        end else begin : g_mid_n
            assign next_d = cell_data[g+1];
        end
        oli_cell u_cell (
            .i_clk   (i_clk),
            .i_index (t_index'(g)),
            .i_ctrl  (ctrl),
            .i_prev  (prev_d),
            .i_next  (next_d),
            .o_data  (cell_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_emit_idx  <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_dropped <= n_dropped;
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state    <= ST_EMIT;
                        r_emit_idx <= '0;
                    end
                end
                ST_EMIT: begin
                    if (load) begin
                        r_out_valid <= 1'b1;
                        r_emit_idx  <= r_emit_idx + t_count'(1);
                        if (last_word) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item     <= (r_count == '0) ? '0 : cell_data[0];
            r_last     <= last_word;
            r_empty    <= (r_count == '0);
            r_out_drop <= r_dropped;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.item_value   = r_item;
    assign o_rsp.last_of_run  = r_last;
    assign o_rsp.list_empty   = r_empty;
    assign o_rsp.dropped_full = r_out_drop;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_count != '0) |-> (r_emit_idx < r_count))
        else $error("emit index past entry count");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |=> $stable(r_count))
        else $error("entry count changed during emission");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.list_empty) |-> o_rsp.last_of_run)
        else $error("empty word not marked last");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;

    import oli_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam t_value VALUE_MIN = 32'sh8000_0000;
    localparam t_value VALUE_MAX = 32'sh7FFF_FFFF;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct {
        logic [FUNC_W-1:0] func;
        t_value            value;
        t_pos              position;
        t_idle_mode        mode;
    } t_request;

    typedef struct {
        t_value value;
        logic   last;
        logic   empty;
        logic   dropped;
    } t_list_word;

    logic i_clk;
    logic i_rst_n;

    oli_req_if req_bus ();
    oli_rsp_if rsp_bus ();

    ordered_list_insert_delete_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    t_request   pending_requests[$];
    t_list_word expected_words[$];
    t_request   in_flight;
    t_idle_mode active_mode;
    t_value     shadow_list[CAPACITY];
    int         shadow_count;
    int         planned_count;
    int         mismatch_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic bit hold_off(t_idle_mode mode, bit sender_side);
        int percent;
        percent = 0;
        if (mode == IDLE_BOTH) begin
            percent = 29;
        end else if (sender_side && mode == IDLE_SENDER) begin
            percent = 82;
        end else if (!sender_side && mode == IDLE_RECEIVER) begin
            percent = 82;
        end
        return $urandom_range(0, 99) < percent;
    endfunction

    // Updates the shadow list for one accepted request and queues the words it emits.
    function automatic void apply_request(t_request rq);
        bit         dropped;
        int         k;
        t_list_word w;
        dropped = 1'b0;
        case (rq.func)
            FUNC_INS_FRONT, FUNC_INS_BACK: begin
                if (shadow_count >= CAPACITY) begin
                    dropped = 1'b1;
                end else if (rq.func == FUNC_INS_FRONT) begin
                    for (k = shadow_count; k > 0; k--) begin
                        shadow_list[k] = shadow_list[k-1];
                    end
                    shadow_list[0] = rq.value;
                    shadow_count++;
                end else begin
                    shadow_list[shadow_count] = rq.value;
                    shadow_count++;
                end
            end
            FUNC_DELETE: begin
                if (int'(rq.position) < shadow_count) begin
                    for (k = int'(rq.position); k + 1 < shadow_count; k++) begin
                        shadow_list[k] = shadow_list[k+1];
                    end
                    shadow_count--;
                end
            end
            default: begin
            end
        endcase
        if (shadow_count == 0) begin
            w.value   = '0;
            w.last    = 1'b1;
            w.empty   = 1'b1;
            w.dropped = dropped;
            expected_words.push_back(w);
        end else begin
            for (k = 0; k < shadow_count; k++) begin
                w.value   = shadow_list[k];
                w.last    = (k + 1 == shadow_count);
                w.empty   = 1'b0;
                w.dropped = dropped;
                expected_words.push_back(w);
            end
        end
    endfunction

    function automatic void note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void plan_request(logic [FUNC_W-1:0] func, t_value value, t_pos position,
                                         t_idle_mode mode);
        t_request rq;
        rq.func     = func;
        rq.value    = value;
        rq.position = position;
        rq.mode     = mode;
        pending_requests.push_back(rq);
        if ((func == FUNC_INS_FRONT || func == FUNC_INS_BACK) && planned_count < CAPACITY) begin
            planned_count++;
        end else if (func == FUNC_DELETE && int'(position) < planned_count) begin
            planned_count--;
        end
    endfunction

    function automatic t_value pick_value();
        case ($urandom_range(0, 15))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return '0;
            3: return -1;
            default: return t_value'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                apply_request(in_flight);
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (pending_requests.size() != 0 &&
                    !hold_off(pending_requests[0].mode, 1'b1)) begin
                    in_flight = pending_requests.pop_front();
                    active_mode      <= in_flight.mode;
                    req_bus.valid    <= 1'b1;
                    req_bus.func     <= in_flight.func;
                    req_bus.value    <= in_flight.value;
                    req_bus.position <= in_flight.position;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_list_word want;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_words.size() == 0) begin
                    note_mismatch({$sformatf("unexpected word: value %0d last %0b",
                                             rsp_bus.item_value, rsp_bus.last_of_run),
                                   $sformatf(" empty %0b dropped %0b",
                                             rsp_bus.list_empty, rsp_bus.dropped_full)});
                end else begin
                    want = expected_words.pop_front();
                    if (rsp_bus.last_of_run !== want.last || rsp_bus.list_empty !== want.empty ||
                        rsp_bus.dropped_full !== want.dropped ||
                        (!want.empty && rsp_bus.item_value !== want.value)) begin
                        note_mismatch({
                            $sformatf("word differs: expected value %0d last %0b empty %0b",
                                      want.value, want.last, want.empty),
                            $sformatf(" dropped %0b, got value %0d last %0b",
                                      want.dropped, rsp_bus.item_value, rsp_bus.last_of_run),
                            $sformatf(" empty %0b dropped %0b",
                                      rsp_bus.list_empty, rsp_bus.dropped_full)});
                    end
                end
            end
            rsp_bus.ready <= !hold_off(active_mode, 1'b0);
        end
    end

    initial begin
        int         i;
        int         r;
        bit         growing;
        t_idle_mode mode;
        t_pos       pos;

        i_rst_n          = 1'b0;
        req_bus.valid    = 1'b0;
        req_bus.func     = FUNC_INS_FRONT;
        req_bus.value    = '0;
        req_bus.position = '0;
        rsp_bus.ready    = 1'b0;
        active_mode      = IDLE_NONE;
        shadow_count     = 0;
        planned_count    = 0;
        mismatch_count   = 0;

        // Start from an empty list, build it up to capacity, overflow it, then trim.
        plan_request(FUNC_DELETE, VALUE_MAX, 6'd0, IDLE_NONE);
        plan_request(FUNC_UNUSED, VALUE_MIN, 6'd63, IDLE_NONE);
        plan_request(FUNC_INS_FRONT, VALUE_MIN, 6'd63, IDLE_NONE);
        plan_request(FUNC_INS_BACK, VALUE_MAX, 6'd63, IDLE_NONE);
        plan_request(FUNC_INS_FRONT, '0, 6'd0, IDLE_NONE);
        plan_request(FUNC_INS_BACK, -1, 6'd42, IDLE_NONE);
        for (i = 0; i < CAPACITY - 4; i++) begin
            plan_request((i % 2 == 0) ? FUNC_INS_FRONT : FUNC_INS_BACK, pick_value(),
                         t_pos'($urandom), IDLE_NONE);
        end
        plan_request(FUNC_INS_FRONT, 32'sh1234_5678, 6'd0, IDLE_NONE);
        plan_request(FUNC_INS_BACK, 32'sh1234_5678, 6'd0, IDLE_NONE);
        plan_request(FUNC_UNUSED, '0, 6'd0, IDLE_NONE);
        plan_request(FUNC_DELETE, VALUE_MIN, t_pos'(CAPACITY - 1), IDLE_NONE);
        plan_request(FUNC_DELETE, '0, 6'd0, IDLE_NONE);
        plan_request(FUNC_DELETE, -1, 6'd63, IDLE_NONE);
        plan_request(FUNC_DELETE, '0, t_pos'(CAPACITY - 2), IDLE_NONE);

        growing = 1'b0;
        for (i = 0; i < 248; i++) begin
            mode = t_idle_mode'(i / 62);
            if (planned_count == CAPACITY && $urandom_range(0, 3) == 0) begin
                growing = 1'b0;
            end else if (planned_count == 0 && $urandom_range(0, 1) == 0) begin
                growing = 1'b1;
            end else if ($urandom_range(0, 19) == 0) begin
                growing = !growing;
            end
            r = $urandom_range(0, 99);
            if (r < 5) begin
                plan_request(FUNC_UNUSED, pick_value(), t_pos'($urandom), mode);
            end else if (r < 12) begin
                pos = t_pos'($urandom_range(planned_count, 63));
                plan_request(FUNC_DELETE, pick_value(), pos, mode);
            end else if ((growing && r < 80) || (!growing && r >= 76)) begin
                plan_request(($urandom_range(0, 1) == 0) ? FUNC_INS_FRONT : FUNC_INS_BACK,
                             pick_value(), t_pos'($urandom), mode);
            end else begin
                if (planned_count > 0) begin
                    pos = t_pos'($urandom_range(0, planned_count - 1));
                end else begin
                    pos = t_pos'($urandom);
                end
                plan_request(FUNC_DELETE, pick_value(), pos, mode);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || req_bus.valid) begin
            @(posedge i_clk);
        end
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * CAPACITY + 8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== ordered_list_insert_delete_top.f =====
sv/oli_pkg.sv
sv/oli_req_if.sv
sv/oli_rsp_if.sv
sv/oli_cell.sv
sv/ordered_list_insert_delete_top.sv
bench/tb_top.sv
